### sv/response_frame_crc_checker_macros.svh
// Assertion macros for the response frame CRC checker.
// Used by the parser and the result queue; no other dependencies.
`ifndef RESPONSE_FRAME_CRC_CHECKER_MACROS_SVH
`define RESPONSE_FRAME_CRC_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define RFCC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rfcc assertion failed");
`define RFCC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rfcc assertion failed");
`else
`define RFCC_ASSERT(label, clk, rst, prop)
`define RFCC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

### sv/rfcc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the checker.
// No dependencies.
package rfcc_pkg;

  localparam logic [7:0]  MAX_FRAME_DATA = 8'd128;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_TRUNC    = 2'd3
  } rfcc_status_t;

  // Packed lowest field last: frame_done sits at bit 0.
  typedef struct packed {
    logic         ready_flag;
    logic         fault_flag;
    rfcc_status_t buffer_status;
    logic [15:0]  crc_received;
    logic [15:0]  crc_computed;
    logic [15:0]  register_address;
    logic [7:0]   device_address;
    logic [7:0]   data_length;
    logic         frame_crc_ok;
    logic         frame_done;
  } rfcc_payload_t;

  typedef struct packed {
    logic          buffer_end;
    rfcc_payload_t payload;
  } rfcc_result_t;

  function automatic logic [15:0] rfcc_crc_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/rfcc_front.sv
// Frame parser: tracks frame phase, CRC and buffer status per received word.
// Depends on rfcc_pkg and the assertion macros header.
`include "response_frame_crc_checker_macros.svh"
module rfcc_front import rfcc_pkg::*; #(
  parameter int MIN_BUFFER_BYTES = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  input  logic         buffer_last,
  output logic         push,
  output rfcc_result_t result
);

  localparam int CNT_W = $clog2(MIN_BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MIN_BUFFER_BYTES);

  typedef enum logic [2:0] {
    PH_HEADER, PH_DEVICE, PH_REG_HI, PH_REG_LO, PH_DATA, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       data_rem, data_rem_next;
  logic [7:0]       frame_len, frame_len_next;
  logic [15:0]      crc, crc_next;
  logic [7:0]       crc_lo, crc_lo_next;
  logic [7:0]       held_dev, held_dev_next;
  logic [15:0]      held_reg, held_reg_next;
  logic [CNT_W-1:0] byte_cnt, byte_cnt_next;
  logic             discarding, discarding_next;
  logic             fault, fault_next;
  logic             ready, ready_next;

  logic [15:0] crc_upd;
  logic [7:0]  len_raw;
  logic [15:0] rx_crc;
  logic        closed;
  logic        ok;

  assign crc_upd = rfcc_crc_byte((phase == PH_HEADER) ? CRC_INIT : crc, rx_byte);
  assign len_raw = {1'b0, rx_byte[6:0]} + 8'd1;
  assign rx_crc  = {rx_byte, crc_lo};

  always_comb begin
    phase_next      = phase;
    data_rem_next   = data_rem;
    frame_len_next  = frame_len;
    crc_next        = crc;
    crc_lo_next     = crc_lo;
    held_dev_next   = held_dev;
    held_reg_next   = held_reg;
    byte_cnt_next   = byte_cnt;
    discarding_next = discarding;
    fault_next      = fault;
    ready_next      = ready;
    closed          = 1'b0;
    ok              = 1'b0;
    result          = '0;

    if (accept) begin
      if (byte_cnt == '0) begin
        ready_next = 1'b0;
      end
      if (byte_cnt < CNT_MAX) begin
        byte_cnt_next = byte_cnt + 1'b1;
      end

      if (!discarding) begin
        case (phase)
          PH_HEADER: begin
            frame_len_next = (len_raw > MAX_FRAME_DATA) ? MAX_FRAME_DATA : len_raw;
            data_rem_next  = (len_raw > MAX_FRAME_DATA) ? MAX_FRAME_DATA : len_raw;
            crc_next       = crc_upd;
            phase_next     = PH_DEVICE;
          end
          PH_DEVICE: begin
            held_dev_next = rx_byte;
            crc_next      = crc_upd;
            phase_next    = PH_REG_HI;
          end
          PH_REG_HI: begin
            held_reg_next = {rx_byte, 8'h00};
            crc_next      = crc_upd;
            phase_next    = PH_REG_LO;
          end
          PH_REG_LO: begin
            held_reg_next = {held_reg[15:8], rx_byte};
            crc_next      = crc_upd;
            phase_next    = PH_DATA;
          end
          PH_DATA: begin
            crc_next = crc_upd;
            if (data_rem != '0) begin
              data_rem_next = data_rem - 8'd1;
            end
            if (data_rem_next == '0) begin
              phase_next = PH_CRC_LO;
            end
          end
          PH_CRC_LO: begin
            crc_lo_next = rx_byte;
            phase_next  = PH_CRC_HI;
          end
          default: begin
            closed = 1'b1;
            ok     = (rx_crc == crc);
            if (!ok) begin
              fault_next      = 1'b1;
              discarding_next = 1'b1;
            end
            phase_next = PH_HEADER;
          end
        endcase
      end

      if (closed) begin
        result.payload.frame_done       = 1'b1;
        result.payload.frame_crc_ok     = ok;
        result.payload.data_length      = frame_len;
        result.payload.device_address   = held_dev;
        result.payload.register_address = held_reg;
        result.payload.crc_computed     = crc;
        result.payload.crc_received     = rx_crc;
      end

      if (buffer_last) begin
        if (byte_cnt_next < CNT_MAX) begin
          result.payload.buffer_status = ST_SHORT;
        end else if (discarding_next) begin
          result.payload.buffer_status = ST_CRC_ERR;
        end else if (phase_next != PH_HEADER) begin
          result.payload.buffer_status = ST_TRUNC;
          fault_next = 1'b1;
        end else begin
          result.payload.buffer_status = ST_OK;
          fault_next = 1'b0;
          ready_next = 1'b1;
        end
        result.buffer_end = 1'b1;
        phase_next      = PH_HEADER;
        data_rem_next   = '0;
        frame_len_next  = '0;
        crc_next        = CRC_INIT;
        crc_lo_next     = '0;
        held_dev_next   = '0;
        held_reg_next   = '0;
        byte_cnt_next   = '0;
        discarding_next = 1'b0;
      end

      result.payload.fault_flag = fault_next;
      result.payload.ready_flag = ready_next;
    end
  end

  assign push = accept && (closed || buffer_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      data_rem   <= '0;
      frame_len  <= '0;
      crc        <= CRC_INIT;
      crc_lo     <= '0;
      held_dev   <= '0;
      held_reg   <= '0;
      byte_cnt   <= '0;
      discarding <= 1'b0;
      fault      <= 1'b0;
      ready      <= 1'b0;
    end else begin
      phase      <= phase_next;
      data_rem   <= data_rem_next;
      frame_len  <= frame_len_next;
      crc        <= crc_next;
      crc_lo     <= crc_lo_next;
      held_dev   <= held_dev_next;
      held_reg   <= held_reg_next;
      byte_cnt   <= byte_cnt_next;
      discarding <= discarding_next;
      fault      <= fault_next;
      ready      <= ready_next;
    end
  end

  `RFCC_ASSERT(a_cnt_sat, clk, rst, byte_cnt <= CNT_MAX)
  `RFCC_ASSERT(a_ok_end_ready, clk, rst,
    !(push && result.buffer_end && result.payload.buffer_status == ST_OK) ||
    (result.payload.ready_flag && !result.payload.fault_flag))
  `RFCC_ASSERT_NEXT(a_mismatch_fault, clk, rst,
    push && result.payload.frame_done && !result.payload.frame_crc_ok, fault)

endmodule

### sv/rfcc_queue.sv
// Result queue between the parser and the output stream.
// Depends on rfcc_pkg and the assertion macros header.
`include "response_frame_crc_checker_macros.svh"
module rfcc_queue import rfcc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  rfcc_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output rfcc_result_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rfcc_result_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign full      = (count == CNT_FULL);
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  `RFCC_ASSERT(a_no_overflow, clk, rst, !(push && full))
  `RFCC_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 1'b1)

endmodule

### sv/response_frame_crc_checker.sv
// Response frame CRC checker: one received byte per word in, checked-frame and
// end-of-buffer reports out. A word that produces a report is queued and shows
// on m_tdata once earlier reports have drained; one word per cycle sustained,
// s_tready falls only while the QUEUE_DEPTH-entry result queue is full behind a
// stalled m side. rst (synchronous, active high) clears the parser state, flags
// and queue at once. Depends on rfcc_pkg, rfcc_front and rfcc_queue.
module response_frame_crc_checker import rfcc_pkg::*; #(
  parameter int MIN_BUFFER_BYTES = 6,
  parameter int QUEUE_DEPTH      = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // buffer_last
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] frame_done, [1] frame_crc_ok, [9:2] data_length, [17:10] device_address,
  // [33:18] register_address, [49:34] crc_computed, [65:50] crc_received,
  // [67:66] buffer_status, [68] fault_flag, [69] ready_flag, [71:70] zero
  output logic [71:0] m_tdata,
  output logic        m_tlast    // buffer_end
);

  logic         accept;
  logic         push;
  logic         full;
  rfcc_result_t result;
  rfcc_result_t head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  rfcc_front #(
    .MIN_BUFFER_BYTES(MIN_BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .buffer_last(s_tlast),
    .push       (push),
    .result     (result)
  );

  rfcc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(result),
    .full     (full),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (head)
  );

  assign m_tdata = {2'b00, head.payload};
  assign m_tlast = head.buffer_end;

endmodule
